FILE: rtl/core/saaa_pkg.sv
// Package with shared constants and the arctangent table for the angle pipeline.
`timescale 1ns / 1ps
package saaa_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam int NORM_BITS = 16;
	localparam int ISQRT_BITS = 48;
	localparam int RAD_WIDTH = 96;
	localparam int ZW = 32;
	localparam logic [ZW-1:0] HALF_PI_Q30 = 32'd1686629713;

	typedef logic signed [NORM_BITS-1:0] norm_t;

	// Arctangent of 2^-i in Q30 radians, truncated.
	function automatic logic [ZW-1:0] atan_q30(input logic [4:0] idx);
		logic [ZW-1:0] r;
		begin
			case (idx)
				5'd0: r = 32'h3243F6A8;
				5'd1: r = 32'h1DAC6705;
				5'd2: r = 32'h0FADBAFC;
				5'd3: r = 32'h07F56EA6;
				5'd4: r = 32'h03FEAB76;
				5'd5: r = 32'h01FFD55B;
				5'd6: r = 32'h00FFFAAA;
				5'd7: r = 32'h007FFF55;
				5'd8: r = 32'h003FFFEA;
				5'd9: r = 32'h001FFFFD;
				5'd10: r = 32'h000FFFFF;
				5'd11: r = 32'h0007FFFF;
				5'd12: r = 32'h0003FFFF;
				5'd13: r = 32'h0001FFFF;
				5'd14: r = 32'h0000FFFF;
				5'd15: r = 32'h00007FFF;
				5'd16: r = 32'h00003FFF;
				5'd17: r = 32'h00001FFF;
				5'd18: r = 32'h00000FFF;
				5'd19: r = 32'h000007FF;
				5'd20: r = 32'h000003FF;
				5'd21: r = 32'h000001FF;
				5'd22: r = 32'h000000FF;
				5'd23: r = 32'h0000007F;
				5'd24: r = 32'h0000003F;
				5'd25: r = 32'h0000001F;
				5'd26: r = 32'h0000000F;
				5'd27: r = 32'h00000007;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/core/saaa_norm.sv
// Scales one vector so its largest magnitude lies in [2^14, 2^15).
`timescale 1ns / 1ps
module saaa_norm #(
	parameter int W = 17
) (
	input  logic signed [W-1:0] vx,
	input  logic signed [W-1:0] vy,
	input  logic signed [W-1:0] vz,
	output saaa_pkg::norm_t     ox,
	output saaa_pkg::norm_t     oy,
	output saaa_pkg::norm_t     oz,
	output logic                nonzero
);
	import saaa_pkg::*;

	logic [W-1:0] mx, my, mz, mor;
	logic [$clog2(W+1)-1:0] top;
	logic found;

	function automatic norm_t scl(input logic signed [W-1:0] v,
			input logic [W-1:0] mg, input logic [$clog2(W+1)-1:0] t);
		logic [W+15:0] ext;
		logic [W+15:0] sh;
		logic [15:0] m;
		begin
			ext = {16'd0, mg};
			// bring bit t of the word to bit 14 (truncating toward zero)
			sh = (ext << 14) >> t;
			m = sh[15:0];
			return v[W-1] ? norm_t'(-$signed({1'b0, m[14:0]})) : norm_t'({1'b0, m[14:0]});
		end
	endfunction

	assign mx = vx[W-1] ? W'(-vx) : W'(vx);
	assign my = vy[W-1] ? W'(-vy) : W'(vy);
	assign mz = vz[W-1] ? W'(-vz) : W'(vz);
	assign mor = mx | my | mz;

	// Leading one of the OR of magnitudes gives the scale of the largest one.
	always_comb begin
		top = '0;
		found = 1'b0;
		for (int i = W - 1; i >= 0; i--) begin
			if (!found && mor[i]) begin
				top = ($clog2(W+1))'(i);
				found = 1'b1;
			end
		end
	end

	assign nonzero = found;
	assign ox = scl(vx, mx, top);
	assign oy = scl(vy, my, top);
	assign oz = scl(vz, mz, top);

endmodule

FILE: rtl/core/saaa_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module saaa_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [saaa_pkg::RAD_WIDTH-1:0]   rad,
	output logic [saaa_pkg::ISQRT_BITS-1:0]  root
);
	import saaa_pkg::*;

	// Restoring digit recurrence: remainder and root per stage.
	logic [RAD_WIDTH-1:0] rem_s[ISQRT_BITS+1];
	logic [RAD_WIDTH-1:0] val_s[ISQRT_BITS+1];
	logic [ISQRT_BITS-1:0] r_s[ISQRT_BITS+1];

	assign val_s[0] = rad;
	assign rem_s[0] = '0;
	assign r_s[0] = '0;

	for (genvar k = 0; k < ISQRT_BITS; k++) begin : g_stage
		logic [RAD_WIDTH-1:0] rem_n, trial;
		logic [RAD_WIDTH-1:0] val_q, rem_q;
		logic [ISQRT_BITS-1:0] r_q;
		always_comb begin
			rem_n = {rem_s[k][RAD_WIDTH-3:0], val_s[k][RAD_WIDTH-1:RAD_WIDTH-2]};
			trial = {{(RAD_WIDTH-ISQRT_BITS-2){1'b0}}, r_s[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				r_q <= '0;
				rem_q <= '0;
				val_q <= '0;
			end else if (en) begin
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					r_q <= {r_s[k][ISQRT_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					r_q <= {r_s[k][ISQRT_BITS-2:0], 1'b0};
				end
				val_q <= {val_s[k][RAD_WIDTH-3:0], 2'b00};
			end
		end
		assign rem_s[k+1] = rem_q;
		assign val_s[k+1] = val_q;
		assign r_s[k+1] = r_q;
	end

	assign root = r_s[ISQRT_BITS];

endmodule

FILE: rtl/core/signed_angle_about_axis.sv
// Top level: signed angle about an axis, fully pipelined.
// Throughput: one word per cycle when not stalled; a stall freezes every stage together.
// Timing is set by 9 front stages, the 48-stage square root, one shift stage and 28 CORDIC stages.
// Reset: arst_n clears all valid bits and the square-root stage registers asynchronously; other data is not reset.
`timescale 1ns / 1ps
module signed_angle_about_axis #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] axis_x,
	input  logic signed [COORD_WIDTH-1:0] axis_y,
	input  logic signed [COORD_WIDTH-1:0] axis_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            angle
);
	import saaa_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int LAT = 9 + ISQRT_BITS + 1 + CORDIC_STEPS;

	logic en;
	logic [LAT-1:0] vld_q;

	// Whole pipeline advances unless the last word is held.
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// Stage 1: differences.
	logic signed [DW-1:0] s_s1[3], e_s1[3], c_s1[3];
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1[0] <= DW'(first_x) - DW'(origin_x);
			s_s1[1] <= DW'(first_y) - DW'(origin_y);
			s_s1[2] <= DW'(first_z) - DW'(origin_z);
			e_s1[0] <= DW'(second_x) - DW'(origin_x);
			e_s1[1] <= DW'(second_y) - DW'(origin_y);
			e_s1[2] <= DW'(second_z) - DW'(origin_z);
			c_s1[0] <= DW'(axis_x);
			c_s1[1] <= DW'(axis_y);
			c_s1[2] <= DW'(axis_z);
		end
	end

	// Stage 2: normalize the three vectors.
	norm_t sn[3], en_v[3], cn[3];
	logic snz, enz, cnz;
	saaa_norm #(.W(DW)) u_ns (.vx(s_s1[0]), .vy(s_s1[1]), .vz(s_s1[2]),
		.ox(sn[0]), .oy(sn[1]), .oz(sn[2]), .nonzero(snz));
	saaa_norm #(.W(DW)) u_ne (.vx(e_s1[0]), .vy(e_s1[1]), .vz(e_s1[2]),
		.ox(en_v[0]), .oy(en_v[1]), .oz(en_v[2]), .nonzero(enz));
	saaa_norm #(.W(DW)) u_nc (.vx(c_s1[0]), .vy(c_s1[1]), .vz(c_s1[2]),
		.ox(cn[0]), .oy(cn[1]), .oz(cn[2]), .nonzero(cnz));

	norm_t s_s2[3], e_s2[3], c_s2[3];
	logic ok_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= sn;
			e_s2 <= en_v;
			c_s2 <= cn;
			ok_s2 <= snz && enz && cnz;
		end
	end

	// Stage 3: cross product partials and squares.
	logic signed [31:0] p_s3[6];
	logic [31:0] sq_s3[9];
	norm_t c_s3[3];
	logic ok_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[0] <= s_s2[1] * e_s2[2];
			p_s3[1] <= s_s2[2] * e_s2[1];
			p_s3[2] <= s_s2[2] * e_s2[0];
			p_s3[3] <= s_s2[0] * e_s2[2];
			p_s3[4] <= s_s2[0] * e_s2[1];
			p_s3[5] <= s_s2[1] * e_s2[0];
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 32'(s_s2[i] * s_s2[i]);
				sq_s3[3+i] <= 32'(e_s2[i] * e_s2[i]);
				sq_s3[6+i] <= 32'(c_s2[i] * c_s2[i]);
			end
			c_s3 <= c_s2;
			ok_s3 <= ok_s2;
		end
	end

	// Stage 4: cross product and squared lengths.
	logic signed [32:0] a_s4[3];
	logic [31:0] l2_s4[3];
	norm_t c_s4[3];
	logic ok_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s4[0] <= 33'(p_s3[0]) - 33'(p_s3[1]);
			a_s4[1] <= 33'(p_s3[2]) - 33'(p_s3[3]);
			a_s4[2] <= 33'(p_s3[4]) - 33'(p_s3[5]);
			l2_s4[0] <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			l2_s4[1] <= sq_s3[3] + sq_s3[4] + sq_s3[5];
			l2_s4[2] <= sq_s3[6] + sq_s3[7] + sq_s3[8];
			c_s4 <= c_s3;
			ok_s4 <= ok_s3;
		end
	end

	// Stage 5: axis products and length product.
	logic signed [48:0] t_s5[3];
	logic [63:0] se_s5;
	logic [31:0] c2_s5;
	logic ok_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) t_s5[i] <= 49'(c_s4[i]) * 49'(a_s4[i]);
			se_s5 <= 64'(l2_s4[0]) * 64'(l2_s4[1]);
			c2_s5 <= l2_s4[2];
			ok_s5 <= ok_s4;
		end
	end

	// Stage 6: N and its magnitude.
	logic [49:0] an_s6;
	logic neg_s6, ok_s6;
	logic [63:0] se_s6;
	logic [31:0] c2_s6;
	logic signed [50:0] nsum;
	assign nsum = 51'(t_s5[0]) + 51'(t_s5[1]) + 51'(t_s5[2]);
	always_ff @(posedge clk) begin
		if (en) begin
			an_s6 <= nsum[50] ? 50'(-nsum) : 50'(nsum);
			neg_s6 <= nsum[50];
			ok_s6 <= ok_s5 && (nsum != '0);
			se_s6 <= se_s5;
			c2_s6 <= c2_s5;
		end
	end

	// Stage 7: partial products for the squares, each at most 32 by 32 bits.
	logic [24:0] anh, anl;
	logic [63:0] pl_s7, ph_s7;
	logic [49:0] nhh_s7, nhl_s7, nll_s7;
	logic [49:0] an_s7;
	logic neg_s7, ok_s7;
	assign anh = an_s6[49:25];
	assign anl = an_s6[24:0];
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s7 <= 64'(se_s6[31:0]) * 64'(c2_s6);
			ph_s7 <= 64'(se_s6[63:32]) * 64'(c2_s6);
			nhh_s7 <= 50'(anh) * 50'(anh);
			nhl_s7 <= 50'(anh) * 50'(anl);
			nll_s7 <= 50'(anl) * 50'(anl);
			an_s7 <= an_s6;
			neg_s7 <= neg_s6;
			ok_s7 <= ok_s6;
		end
	end

	// Stage 8: squares of N and of the length product from the partials.
	logic [RAD_WIDTH-1:0] pp_s8, nn_s8;
	logic [49:0] an_s8;
	logic neg_s8, ok_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			pp_s8 <= (RAD_WIDTH'(ph_s7) << 32) + RAD_WIDTH'(pl_s7);
			nn_s8 <= (RAD_WIDTH'(nhh_s7) << 50) + (RAD_WIDTH'(nhl_s7) << 26)
				+ RAD_WIDTH'(nll_s7);
			an_s8 <= an_s7;
			neg_s8 <= neg_s7;
			ok_s8 <= ok_s7;
		end
	end

	// Stage 9: radicand, clamped at zero.
	logic [RAD_WIDTH-1:0] rad_s9;
	logic [49:0] an_s9;
	logic neg_s9, ok_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s9 <= (pp_s8 <= nn_s8) ? '0 : pp_s8 - nn_s8;
			an_s9 <= an_s8;
			neg_s9 <= neg_s8;
			ok_s9 <= ok_s8;
		end
	end

	// Square root with side data delayed alongside.
	logic [ISQRT_BITS-1:0] q_r;
	saaa_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .en(en), .rad(rad_s9), .root(q_r));

	logic [49:0] an_d[ISQRT_BITS+1];
	logic neg_d[ISQRT_BITS+1], ok_d[ISQRT_BITS+1];
	assign an_d[0] = an_s9;
	assign neg_d[0] = neg_s9;
	assign ok_d[0] = ok_s9;
	for (genvar k = 0; k < ISQRT_BITS; k++) begin : g_dly
		logic [49:0] a_q;
		logic n_q, o_q;
		always_ff @(posedge clk) begin
			if (en) begin
				a_q <= an_d[k];
				n_q <= neg_d[k];
				o_q <= ok_d[k];
			end
		end
		assign an_d[k+1] = a_q;
		assign neg_d[k+1] = n_q;
		assign ok_d[k+1] = o_q;
	end

	// Joint right shift of Q and |N| until both are below 2^30.
	logic [49:0] qa, na;
	always_comb begin
		qa = 50'(q_r);
		na = an_d[ISQRT_BITS];
		for (int sh = 20; sh >= 1; sh--) begin
			if ((qa | na) >> 30 != '0 && ((qa | na) >> (30 + sh - 1)) != '0
					&& ((qa | na) >> (30 + sh)) == '0) begin
				qa = qa >> sh;
				na = na >> sh;
			end
		end
	end

	logic signed [32:0] x_c[CORDIC_STEPS+1], y_c[CORDIC_STEPS+1];
	logic signed [ZW:0] z_c[CORDIC_STEPS+1];
	logic neg_c[CORDIC_STEPS+1], ok_c[CORDIC_STEPS+1];
	always_ff @(posedge clk) begin
		if (en) begin
			x_c[0] <= 33'(qa[29:0]);
			y_c[0] <= 33'(na[29:0]);
			z_c[0] <= '0;
			neg_c[0] <= neg_d[ISQRT_BITS];
			ok_c[0] <= ok_d[ISQRT_BITS];
		end
	end

	// CORDIC vectoring, one iteration per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_c[i][32]) begin
					x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] + (ZW+1)'(atan_q30(5'(i)));
				end else begin
					x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] - (ZW+1)'(atan_q30(5'(i)));
				end
				neg_c[i+1] <= neg_c[i];
				ok_c[i+1] <= ok_c[i];
			end
		end
	end

	// Clamp, round and sign; zero when the input was degenerate.
	logic signed [ZW:0] zc;
	logic signed [ZW+1:0] rr;
	always_comb begin
		zc = z_c[CORDIC_STEPS];
		if (zc[ZW]) zc = '0;
		if (zc > $signed({1'b0, HALF_PI_Q30})) zc = $signed({1'b0, HALF_PI_Q30});
		rr = ((ZW+2)'(zc) + ((ZW+2)'(1) <<< (29 - ANGLE_FRAC_BITS)))
			>>> (30 - ANGLE_FRAC_BITS);
		if (neg_c[CORDIC_STEPS]) rr = -rr;
		if (!ok_c[CORDIC_STEPS]) rr = '0;
	end
	assign angle = rr[15:0];

	// Output held steady under backpressure.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle))
		else $error("output word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ANGLE_FRAC_BITS == 14 |-> angle <= 16'sd25736 && angle >= -16'sd25736)
		else $error("angle out of range");

endmodule

FILE: test/signed_angle_about_axis_checker.sv
// Checker that predicts each angle word from the accepted inputs and compares results.
`timescale 1ns / 1ps
module signed_angle_about_axis_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] first_x,
	input  logic signed [15:0] first_y,
	input  logic signed [15:0] first_z,
	input  logic signed [15:0] second_x,
	input  logic signed [15:0] second_y,
	input  logic signed [15:0] second_z,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	input  logic signed [15:0] origin_z,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] angle,
	output int                 fail_count,
	output int                 pending_count,
	output int                 angle_count
);
	import saaa_pkg::*;

	logic [15:0] angle_queue[$];

	// Scale a vector so its largest magnitude lies in [2^14, 2^15); returns 0 for a zero vector.
	function automatic bit normalize_vec(input longint v[3], output longint o[3]);
		longint unsigned mag[3];
		longint unsigned m;
		int up;
		int down;
		begin
			m = 0;
			up = 0;
			down = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
				if (mag[i] > m) m = mag[i];
			end
			if (m == 0) return 0;
			while (m >= 64'd32768) begin m >>= 1; down++; end
			while (m < 64'd16384) begin m <<= 1; up++; end
			for (int i = 0; i < 3; i++) begin
				o[i] = longint'((mag[i] >> down) << up);
				if (v[i] < 0) o[i] = -o[i];
			end
			return 1;
		end
	endfunction

	// Predict the signed angle word for one input word.
	function automatic logic [15:0] predict_angle(input longint pa[3], input longint pb[3],
			input longint po[3], input longint pc[3]);
		longint sv[3], ev[3], sn[3], en[3], cn[3], cr[3];
		longint n, x, y, z, dx, dy, res;
		longint unsigned s2, e2, c2, an, q;
		logic [127:0] prod, nsq, rad, cand;
		begin
			for (int i = 0; i < 3; i++) begin
				sv[i] = pa[i] - po[i];
				ev[i] = pb[i] - po[i];
			end
			if (!normalize_vec(sv, sn) || !normalize_vec(ev, en) || !normalize_vec(pc, cn))
				return 16'd0;
			cr[0] = sn[1] * en[2] - sn[2] * en[1];
			cr[1] = sn[2] * en[0] - sn[0] * en[2];
			cr[2] = sn[0] * en[1] - sn[1] * en[0];
			n = cn[0] * cr[0] + cn[1] * cr[1] + cn[2] * cr[2];
			if (n == 0) return 16'd0;
			s2 = 0;
			e2 = 0;
			c2 = 0;
			for (int i = 0; i < 3; i++) begin
				s2 += longint'(sn[i] * sn[i]);
				e2 += longint'(en[i] * en[i]);
				c2 += longint'(cn[i] * cn[i]);
			end
			prod = 128'(s2 * e2) * 128'(c2);
			an = (n < 0) ? longint'(-n) : longint'(n);
			nsq = 128'(an) * 128'(an);
			rad = (prod <= nsq) ? 128'd0 : prod - nsq;
			// Integer square root, bit by bit from the top.
			q = 0;
			for (int b = ISQRT_BITS - 1; b >= 0; b--) begin
				cand = 128'(q | (64'd1 << b));
				if (cand * cand <= rad) q = q | (64'd1 << b);
			end
			while (q >= 64'd1073741824 || an >= 64'd1073741824) begin
				q >>= 1;
				an >>= 1;
			end
			// Vectoring rotations toward the x axis.
			x = longint'(q);
			y = longint'(an);
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx;
					y -= dy;
					z += longint'(atan_q30(5'(i)));
				end else begin
					x -= dx;
					y += dy;
					z -= longint'(atan_q30(5'(i)));
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
			res = (z + (64'sd1 <<< 15)) >>> 16;
			if (n < 0) res = -res;
			return res[15:0];
		end
	endfunction

	task automatic report_mismatch(input logic [15:0] got, input logic [15:0] want);
		begin
			$display("angle mismatch at %0t: got %0d, expected %0d", $realtime,
				$signed(got), $signed(want));
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		angle_count = 0;
	end

	assign pending_count = angle_queue.size();

	// Predict on each accepted input word and compare each accepted output word.
	always @(posedge clk) begin
		longint pa[3], pb[3], po[3], pc[3];
		logic [15:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pa = '{first_x, first_y, first_z};
				pb = '{second_x, second_y, second_z};
				po = '{origin_x, origin_y, origin_z};
				pc = '{axis_x, axis_y, axis_z};
				angle_queue.push_back(predict_angle(pa, pb, po, pc));
			end
			if (out_valid && out_ready) begin
				angle_count++;
				if (angle_queue.size() == 0) begin
					$display("unexpected angle word %0d at %0t", angle, $realtime);
					fail_count++;
				end else begin
					want = angle_queue.pop_front();
					if (angle !== want) report_mismatch(angle, want);
				end
			end
		end
	end
endmodule

FILE: test/signed_angle_about_axis_tb.sv
// Testbench top: drives angle queries with random gaps and gives the verdict.
`timescale 1ns / 1ps
module signed_angle_about_axis_tb;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] angle;
	logic signed [15:0] fld[12];
	int fail_count;
	int pending_count;
	int angle_count;
	int sent_count;
	bit stim_done;

	signed_angle_about_axis u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.first_x(fld[0]), .first_y(fld[1]), .first_z(fld[2]),
		.second_x(fld[3]), .second_y(fld[4]), .second_z(fld[5]),
		.origin_x(fld[6]), .origin_y(fld[7]), .origin_z(fld[8]),
		.axis_x(fld[9]), .axis_y(fld[10]), .axis_z(fld[11]),
		.out_valid(out_valid), .out_ready(out_ready), .angle(angle)
	);

	signed_angle_about_axis_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.first_x(fld[0]), .first_y(fld[1]), .first_z(fld[2]),
		.second_x(fld[3]), .second_y(fld[4]), .second_z(fld[5]),
		.origin_x(fld[6]), .origin_y(fld[7]), .origin_z(fld[8]),
		.axis_x(fld[9]), .axis_y(fld[10]), .axis_z(fld[11]),
		.out_valid(out_valid), .out_ready(out_ready), .angle(angle),
		.fail_count(fail_count), .pending_count(pending_count), .angle_count(angle_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 55) return 0;
			if (r < 93) return $urandom_range(1, 3);
			return $urandom_range(10, 60);
		end
	endfunction

	function automatic logic signed [15:0] small_coord(input int span);
		begin
			return 16'($signed($urandom_range(0, 2 * span)) - span);
		end
	endfunction

	// Offer one word and hold it until accepted.
	task automatic send_word(input logic signed [15:0] w[12]);
		int g;
		begin
			g = gap_len();
			if (g > 0) begin
				in_valid = 0;
				repeat (g) @(negedge clk);
			end
			fld = w;
			in_valid = 1;
			do @(posedge clk); while (!in_ready);
			sent_count++;
			@(negedge clk);
		end
	endtask

	// Build a random query; the kind picks the special structure.
	task automatic make_random(output logic signed [15:0] w[12]);
		int kind;
		int k;
		begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 12; i++) w[i] = 16'($urandom);
			case (kind)
				0, 1: begin
					// Small vectors around a random vertex.
					for (int i = 0; i < 3; i++) begin
						w[i] = w[6 + i] + small_coord(20);
						w[3 + i] = w[6 + i] + small_coord(20);
						w[9 + i] = small_coord(4);
					end
				end
				2: begin
					// Second point on the line of the first, often parallel.
					k = $urandom_range(1, 3);
					for (int i = 0; i < 3; i++) begin
						w[i] = small_coord(3000);
						w[3 + i] = w[i] * k;
						w[6 + i] = 0;
					end
					if ($urandom_range(0, 1)) w[5] = w[5] + 1;
				end
				3: begin
					// Degenerate: a point on the vertex or a zero axis.
					k = $urandom_range(0, 2);
					for (int i = 0; i < 3; i++) begin
						if (k == 0) w[i] = w[6 + i];
						else if (k == 1) w[3 + i] = w[6 + i];
						else w[9 + i] = 0;
					end
				end
				4: begin
					// Axis lying in the plane of the two vectors.
					for (int i = 0; i < 3; i++) begin
						w[i] = small_coord(100);
						w[3 + i] = small_coord(100);
						w[6 + i] = 0;
						w[9 + i] = w[i] + w[3 + i];
					end
				end
				5: begin
					// Extreme coordinates only.
					for (int i = 0; i < 12; i++)
						w[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				end
				default: ;
			endcase
		end
	endtask

	// Stimulus: directed words, then random ones.
	initial begin
		logic signed [15:0] w[12];
		logic signed [15:0] directed[$][12];
		in_valid = 0;
		sent_count = 0;
		stim_done = 0;
		for (int i = 0; i < 12; i++) fld[i] = 0;
		arst_n = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		directed.push_back('{100, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0, 1});
		directed.push_back('{100, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0, -1});
		directed.push_back('{5, 5, 5, 1, 2, 3, 5, 5, 5, 1, 1, 1});
		directed.push_back('{1, 2, 3, 5, 5, 5, 5, 5, 5, 1, 1, 1});
		directed.push_back('{10, 20, 30, 7, 8, 9, 0, 0, 0, 0, 0, 0});
		directed.push_back('{10, 20, 30, 20, 40, 60, 0, 0, 0, 3, 1, 4});
		directed.push_back('{10, 0, 0, 0, 10, 0, 0, 0, 0, 1, 1, 0});
		directed.push_back('{32767, 32767, 32767, -32768, -32768, -32768,
			-32768, 32767, 0, 32767, -32768, 32767});
		directed.push_back('{32767, 0, 0, 0, 32767, 0, -32768, -32768, 0,
			-32768, -32768, -32768});
		directed.push_back('{-32768, 32767, -32768, 32767, -32768, 32767,
			0, 0, 0, 1, 0, 0});
		directed.push_back('{32767, -32768, 0, 0, 32767, -32768, 0, 0, 0, 32767, 32767, 32767});
		directed.push_back('{1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 32767});
		directed.push_back('{30000, 1, 0, 30000, 0, 1, 0, 0, 0, 0, 32767, 0});
		directed.push_back('{-1, -1, -1, 1, 1, -1, 0, 0, 0, -32768, 0, 0});
		foreach (directed[i]) send_word(directed[i]);
		repeat (1600) begin
			make_random(w);
			send_word(w);
		end
		in_valid = 0;
		stim_done = 1;
	end

	// Receiver: random back-pressure, plus one long hold-off while inputs keep being offered.
	initial begin
		int g;
		bit held;
		out_ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent_count >= 400) begin
				held = 1;
				out_ready = 0;
				repeat (400) @(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				out_ready = 0;
				repeat (g) @(negedge clk);
			end
			out_ready = 1;
		end
	end

	// Wait for all results to drain, then give the verdict.
	initial begin
		@(posedge arst_n);
		wait (stim_done);
		wait (pending_count == 0);
		repeat (150) @(posedge clk);
		$display("Sent %0d query words (directed extremes, degenerate and random).", sent_count);
		$display("Checked %0d angle words under random stalls and one long hold-off.",
			angle_count);
		if (fail_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
